[hw/rtl/pressure_channel_conditioner_defines.svh]
// ----------------------------------------------------------------------------
// Pressure channel conditioner assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_CHANNEL_CONDITIONER_DEFINES_SVH
`define PRESSURE_CHANNEL_CONDITIONER_DEFINES_SVH

// Same-cycle implication.
`define PCC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure channel conditioner package
// Field widths, register codes, reset values, sequencer states and shared
// fixed-point helpers.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 13;
  localparam int PRES_W   = 11;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 24;
  localparam int CODE_W   = 13;
  localparam int OUTV_W   = 10;
  localparam int B0_W     = 23;
  localparam int COEF_W   = 24;
  localparam int ST_W     = 40;
  localparam int FRAC     = 22;
  localparam int HALF     = 20;
  localparam int BX_W     = B0_W + SAMPLE_W;
  localparam int MB_W     = HALF + 1;
  localparam int PROD_W   = COEF_W + MB_W;
  localparam int ACC_W    = 64;
  localparam int RND_W    = ACC_W - FRAC;
  localparam int EXT_W    = 44;
  localparam int V_W      = ST_W - FRAC;
  localparam int VD_W     = V_W + 1;
  localparam int DOUT_W   = OUTV_W + 1;
  localparam int NUM_W    = 30;
  localparam int DEN_W    = CODE_W + 1;
  localparam int PSUM_W   = NUM_W + 1;

  localparam logic signed [ACC_W-1:0] RND_HALF   = ACC_W'(64'd1 << (FRAC - 1));
  localparam logic signed [ST_W-1:0]  TRUNC_BIAS = ST_W'((64'd1 << FRAC) - 64'd1);
  localparam logic signed [EXT_W-1:0] SAT_HI     = EXT_W'((64'd1 << (ST_W - 1)) - 64'd1);
  localparam logic signed [EXT_W-1:0] SAT_LO     = -SAT_HI - EXT_W'(1);
  localparam logic signed [PRES_W-1:0] P_MIN     = -11'sd128;
  localparam logic signed [PRES_W-1:0] P_MAX     = 11'sd1023;

  localparam logic [CODE_W-1:0]        RST_LOW_CODE  = 13'd1951;
  localparam logic [CODE_W-1:0]        RST_HIGH_CODE = 13'd8191;
  localparam logic [OUTV_W-1:0]        RST_OUT_LOW   = 10'd0;
  localparam logic [OUTV_W-1:0]        RST_OUT_HIGH  = 10'd833;
  localparam logic [B0_W-1:0]          RST_COEF_B0   = 23'd56036;
  localparam logic signed [COEF_W-1:0] RST_COEF_A1   = -24'sd6909945;
  localparam logic signed [COEF_W-1:0] RST_COEF_A2   = 24'sd2939746;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_CODE  = 3'd0,
    REG_HIGH_CODE = 3'd1,
    REG_OUT_LOW   = 3'd2,
    REG_OUT_HIGH  = 3'd3,
    REG_COEF_B0   = 3'd4,
    REG_COEF_A1   = 3'd5,
    REG_COEF_A2   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_Y, S_A1L, S_A1H, S_NUM, S_A2L, S_A2H,
    S_ACC2, S_RND2, S_D2, S_WB, S_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0]        low_code;
    logic [CODE_W-1:0]        high_code;
    logic [OUTV_W-1:0]        out_low;
    logic [OUTV_W-1:0]        out_high;
    logic [B0_W-1:0]          coef_b0;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
  } cfg_t;

  typedef struct packed {
    logic signed [ST_W-1:0] d1;
    logic signed [ST_W-1:0] d2;
  } state_rec_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] dividend;
    logic signed [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic signed [NUM_W-1:0] quotient;
  } div_rsp_t;

  // Saturate a widened sum to the signed 40-bit state range.
  function automatic logic signed [ST_W-1:0] sat40(input logic signed [EXT_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[ST_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[ST_W-1:0];
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pcc_intf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure channel conditioner channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface pcc_in_if;
  import pcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface pcc_out_if;
  import pcc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          out_channel;
  logic signed [PRES_W-1:0] pressure;
  modport source (output valid, out_channel, pressure, input ready);
  modport sink   (input valid, out_channel, pressure, output ready);
endinterface

interface pcc_cfg_if;
  import pcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/pressure_channel_conditioner.sv]
// An accepted item steps through S_LOAD to S_WB, waits in S_WAIT for the divider
// and reaches the output register from S_OUT; a channel number beyond the channel
// count goes straight to S_WAIT. A new item is taken only in S_IDLE, once the last
// has left S_OUT; the shared 24x21 multiplier and radix-4 divider set the pace.
// Reset clears every channel's filter state at once through per-entry valid bits,
// loads the register defaults and empties the output register.
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure channel conditioner
// Clamps a sample to the code window, filters it through the channel's biquad
// and maps the result onto the pressure range.
// ----------------------------------------------------------------------------
`include "pressure_channel_conditioner_defines.svh"
module pressure_channel_conditioner #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 13
) (
  input  logic      clk,
  input  logic      rst,
  pcc_cfg_if.sink   cfg,
  pcc_in_if.sink    samples,
  pcc_out_if.source results
);
  import pcc_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((32'd1 << XB) - 32'd1);

  cfg_t       cr;
  state_t     state;
  state_t     state_next;
  state_rec_t rd_data;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic                     accept;
  logic                     oor_in;
  logic [SAMPLE_W-1:0]      x_in;
  logic                     mem_re;
  logic                     mem_we;

  logic [CH_W-1:0]          ch;
  logic                     oor;
  logic [SAMPLE_W-1:0]      xs;
  logic [BX_W-1:0]          bx;
  logic signed [ST_W-1:0]   y;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  r1;
  logic signed [RND_W-1:0]  r2;
  logic signed [ST_W-1:0]   d1n;
  logic signed [ST_W-1:0]   d2n;
  logic signed [VD_W-1:0]   vd;
  logic signed [NUM_W-1:0]  num;
  logic signed [PROD_W-1:0] pq;
  logic signed [PRES_W-1:0] pres;
  logic                     res_valid;
  logic [CH_W-1:0]          res_channel;
  logic signed [PRES_W-1:0] res_pressure;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  pq_ext;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [ST_W-1:0]   y_adj;
  logic signed [V_W-1:0]    v;
  logic signed [DOUT_W-1:0] dout;
  logic signed [DEN_W-1:0]  den;
  logic signed [PSUM_W-1:0] psum;
  logic signed [PRES_W-1:0] p_final;
  logic signed [EXT_W-1:0]  s_y;
  logic signed [EXT_W-1:0]  s_d1;
  logic signed [EXT_W-1:0]  s_d2;

  pcc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cr)
  );

  pcc_state_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_re),
    .rd_addr (AW'(samples.channel)),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (AW'(ch)),
    .wr_data ({d1n, d2n})
  );

  pcc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign oor_in        = ({{(32 - CH_W){1'b0}}, samples.channel} >= 32'(CHANNELS));
  assign x_in          = samples.sample & SAMPLE_MASK;
  assign mem_re        = accept && !oor_in;
  assign mem_we        = (state == S_WB);

  assign den              = $signed({1'b0, cr.high_code}) - $signed({1'b0, cr.low_code});
  assign dout             = $signed({1'b0, cr.out_high}) - $signed({1'b0, cr.out_low});
  assign div_req.start    = (state == S_A2H) && (cr.high_code != cr.low_code);
  assign div_req.dividend = num;
  assign div_req.divisor  = den;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOAD: begin
        mul_a = $signed({1'b0, cr.coef_b0});
        mul_b = $signed(MB_W'(xs));
      end
      S_A1L: begin
        mul_a = cr.coef_a1;
        mul_b = $signed({1'b0, y[HALF-1:0]});
      end
      S_A1H: begin
        mul_a = cr.coef_a1;
        mul_b = $signed({y[ST_W-1], y[ST_W-1:HALF]});
      end
      S_NUM: begin
        mul_a = COEF_W'(dout);
        mul_b = MB_W'(vd);
      end
      S_A2L: begin
        mul_a = cr.coef_a2;
        mul_b = $signed({1'b0, y[HALF-1:0]});
      end
      S_A2H: begin
        mul_a = cr.coef_a2;
        mul_b = $signed({y[ST_W-1], y[ST_W-1:HALF]});
      end
      default: begin
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign pq_ext  = ACC_W'(pq);
  assign rnd_sum = acc + RND_HALF;
  assign y_adj   = y + (y[ST_W-1] ? TRUNC_BIAS : '0);
  assign v       = y_adj[ST_W-1:FRAC];
  assign s_y     = EXT_W'($signed({1'b0, pq[BX_W-1:0]})) + EXT_W'(rd_data.d1);
  assign s_d1    = EXT_W'($signed({1'b0, bx, 1'b0})) + EXT_W'(rd_data.d2) - EXT_W'(r1);
  assign s_d2    = EXT_W'($signed({1'b0, bx})) - EXT_W'(r2);
  assign psum    = PSUM_W'(div_rsp.quotient) + $signed({{(PSUM_W - OUTV_W){1'b0}}, cr.out_low});

  always_comb begin
    if (oor) begin
      p_final = '0;
    end else if (cr.high_code == cr.low_code) begin
      p_final = $signed({1'b0, cr.out_low});
    end else if (psum < PSUM_W'(P_MIN)) begin
      p_final = P_MIN;
    end else if (psum > PSUM_W'(P_MAX)) begin
      p_final = P_MAX;
    end else begin
      p_final = psum[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = oor_in ? S_WAIT : S_LOAD;
        end
      end
      S_LOAD: state_next = S_Y;
      S_Y:    state_next = S_A1L;
      S_A1L:  state_next = S_A1H;
      S_A1H:  state_next = S_NUM;
      S_NUM:  state_next = S_A2L;
      S_A2L:  state_next = S_A2H;
      S_A2H:  state_next = S_ACC2;
      S_ACC2: state_next = S_RND2;
      S_RND2: state_next = S_D2;
      S_D2:   state_next = S_WB;
      S_WB:   state_next = S_WAIT;
      S_WAIT: begin
        if (!div_rsp.busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_valid || results.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pq <= prod;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ch  <= samples.channel;
          oor <= oor_in;
          if (x_in < cr.low_code) begin
            xs <= cr.low_code;
          end else if (x_in > cr.high_code) begin
            xs <= cr.high_code;
          end else begin
            xs <= x_in;
          end
        end
      end
      S_Y: begin
        bx <= pq[BX_W-1:0];
        y  <= sat40(s_y);
      end
      S_A1L: vd <= VD_W'(v) - $signed({{(VD_W - CODE_W){1'b0}}, cr.low_code});
      S_A1H: acc <= pq_ext;
      S_NUM: acc <= acc + (pq_ext <<< HALF);
      S_A2L: begin
        num <= pq[NUM_W-1:0];
        r1  <= rnd_sum[ACC_W-1:FRAC];
      end
      S_A2H: begin
        acc <= pq_ext;
        d1n <= sat40(s_d1);
      end
      S_ACC2: acc <= acc + (pq_ext <<< HALF);
      S_RND2: r2 <= rnd_sum[ACC_W-1:FRAC];
      S_D2:   d2n <= sat40(s_d2);
      S_WAIT: pres <= p_final;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && (!res_valid || results.ready)) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!res_valid || results.ready)) begin
      res_channel  <= ch;
      res_pressure <= pres;
    end
  end

  assign results.valid       = res_valid;
  assign results.out_channel = res_channel;
  assign results.pressure    = res_pressure;

  `PCC_ASSERT_IMPL(a_mem_no_overlap, mem_re, !mem_we, "State read and write collided.")
  `PCC_ASSERT_IMPL(a_oor_no_write, state != S_IDLE && oor, !mem_we,
    "Out-of-range channel wrote filter state.")
  `PCC_ASSERT_IMPL(a_pressure_floor, res_valid, res_pressure >= P_MIN,
    "Pressure below saturation floor.")

endmodule
`default_nettype wire

[hw/rtl/pcc_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure channel conditioner register bank
// Holds the code window, output range and filter coefficients.
// ----------------------------------------------------------------------------
module pcc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  pcc_cfg_if.sink       cfg,
  output pcc_pkg::cfg_t regs
);
  import pcc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_code  <= RST_LOW_CODE;
      regs.high_code <= RST_HIGH_CODE;
      regs.out_low   <= RST_OUT_LOW;
      regs.out_high  <= RST_OUT_HIGH;
      regs.coef_b0   <= RST_COEF_B0;
      regs.coef_a1   <= RST_COEF_A1;
      regs.coef_a2   <= RST_COEF_A2;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_LOW_CODE:  regs.low_code  <= cfg.data[CODE_W-1:0];
        REG_HIGH_CODE: regs.high_code <= cfg.data[CODE_W-1:0];
        REG_OUT_LOW:   regs.out_low   <= cfg.data[OUTV_W-1:0];
        REG_OUT_HIGH:  regs.out_high  <= cfg.data[OUTV_W-1:0];
        REG_COEF_B0:   regs.coef_b0   <= cfg.data[B0_W-1:0];
        REG_COEF_A1:   regs.coef_a1   <= $signed(cfg.data[COEF_W-1:0]);
        REG_COEF_A2:   regs.coef_a2   <= $signed(cfg.data[COEF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pcc_state_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure channel conditioner state memory
// Per-channel biquad delay pair with registered read. Entries not written since
// reset read as zero.
// ----------------------------------------------------------------------------
module pcc_state_mem #(
  parameter int CHANNELS = 8,
  parameter int AW       = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output pcc_pkg::state_rec_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  pcc_pkg::state_rec_t wr_data
);
  import pcc_pkg::*;

  state_rec_t           mem [CHANNELS];
  state_rec_t           rd_q;
  logic                 rd_valid;
  logic [CHANNELS-1:0]  valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

[hw/rtl/pcc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure channel conditioner divider
// Signed division truncating toward zero, radix-4 restoring on magnitudes.
// ----------------------------------------------------------------------------
`include "pressure_channel_conditioner_defines.svh"
module pcc_div (
  input  logic              clk,
  input  logic              rst,
  input  pcc_pkg::div_req_t req,
  output pcc_pkg::div_rsp_t rsp
);
  import pcc_pkg::*;

  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] quo;
  logic [NUM_W-1:0] quo_next;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next, quo_next[NUM_W-1]};
      quo_next = {quo_next[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[NUM_W-1] ^ req.divisor[DEN_W-1];
      quo <= req.dividend[NUM_W-1] ? NUM_W'(-req.dividend) : NUM_W'(req.dividend);
      dvs <= req.divisor[DEN_W-1] ? DEN_W'(-req.divisor) : DEN_W'(req.divisor);
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = neg ? -$signed(quo) : $signed(quo);

  `PCC_ASSERT_IMPL(a_div_no_restart, req.start, !busy, "Divider started while busy.")
  `PCC_ASSERT_IMPL(a_div_rem_bound, busy, rem < dvs, "Partial remainder reached divisor.")
  `PCC_ASSERT_NEXT(a_div_launch, req.start, busy && rem == '0, "Divider failed to launch.")

endmodule
`default_nettype wire
